>>> rtl/core/tlb_with_aging_replacement_top_assert.svh
// Assertion macros for the translation buffer.
// TWAR_ASSERT is muted while reset is asserted; TWAR_ASSERT_RST also checks during reset.
`ifndef TLB_WITH_AGING_REPLACEMENT_TOP_ASSERT_SVH
`define TLB_WITH_AGING_REPLACEMENT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TWAR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("twar assertion failed");
`define TWAR_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("twar reset assertion failed");
`else
`define TWAR_ASSERT(label, clk, rst_n, prop)
`define TWAR_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> rtl/core/twar_pkg.sv
package twar_pkg;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } twar_state_t;

    // per-step control into the compare unit
    typedef struct packed {
        logic lookup;      // 1: page match step, 0: victim search step
        logic first;       // step on entry zero
        logic entry_valid;
        logic found;       // a match was already taken
    } cmp_ctrl_t;

endpackage

>>> rtl/core/twar_ram.sv
module twar_ram import twar_pkg::*; #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/twar_cmp.sv
// Shared compare unit: one entry per step.
module twar_cmp import twar_pkg::*; #(
    parameter int PAGE_BITS = 20,
    parameter int AGE_BITS  = 16
) (
    input  cmp_ctrl_t            ctrl,
    input  logic [PAGE_BITS-1:0] entry_page,
    input  logic [PAGE_BITS-1:0] key_page,
    input  logic [AGE_BITS-1:0]  entry_age,
    input  logic [AGE_BITS-1:0]  best_age,
    output logic                 take
);

    always_comb begin
        if (ctrl.lookup) begin
            // first valid match wins
            take = !ctrl.found && ctrl.entry_valid && (entry_page == key_page);
        end else begin
            // strict less keeps lowest index on ties
            take = ctrl.first || (entry_age < best_age);
        end
    end

endmodule

>>> rtl/core/tlb_with_aging_replacement_top.sv
// A new input is taken only in the idle state; the scan reads one entry per cycle
// through the single read port of the entry RAM into one shared compare unit.
// A result beat still waiting for m_ready holds the update cycle and so the next input.
// Reset (aresetn low, synchronous): all entries invalid, all ages zero, no result pending.
// Page, frame and read-only storage is not cleared; it is only read through valid entries.
`include "tlb_with_aging_replacement_top_assert.svh"

module tlb_with_aging_replacement_top import twar_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int PAGE_BITS  = 20,
    parameter int FRAME_BITS = 16,
    parameter int AGE_BITS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input beat
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [PAGE_BITS-1:0]  s_page,
    input  logic [FRAME_BITS-1:0] s_frame,
    input  logic                  s_is_write,
    input  logic                  s_read_only,
    // result beat
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [FRAME_BITS-1:0] m_found_frame
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = PAGE_BITS + FRAME_BITS + 1;
    localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [AGE_BITS-1:0] AGE_TOP  = {1'b1, {(AGE_BITS-1){1'b0}}};

    // sequencer
    twar_state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg;       // RAM read address during scan
    logic [IDX_W-1:0] cmp_idx_reg;   // entry whose read data is on the bus
    logic             cmp_vld_reg;

    // latched item
    logic                  func_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic                  wr_reg;
    logic                  ro_reg;

    // scan results
    logic                  found_reg;
    logic [IDX_W-1:0]      sel_idx_reg;    // hit entry or victim
    logic [AGE_BITS-1:0]   best_age_reg;
    logic [FRAME_BITS-1:0] hit_frame_reg;

    // per-entry state kept in flops
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [AGE_BITS-1:0] age_reg  [ENTRIES];
    logic [AGE_BITS-1:0] age_next [ENTRIES];

    // result register
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [FRAME_BITS-1:0] m_frame_reg;

    logic s_fire, out_free, commit;
    logic scan_issue;

    // RAM interface
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [FRAME_BITS-1:0] rd_frame;

    cmp_ctrl_t cmp_ctrl;
    logic      cmp_take;

    // assertion helpers
    logic ins_commit;
    logic victim_filled;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SCAN;
            ST_SCAN:   if (cnt_reg == IDX_LAST) state_next = ST_LAST;
            ST_LAST:   state_next = ST_UPDATE;
            ST_UPDATE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_ready    = 1'b0;
        scan_issue = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready    = 1'b1;
            ST_SCAN:   scan_issue = 1'b1;
            ST_LAST:   ;
            ST_UPDATE: commit     = out_free;
            default:   ;
        endcase
    end

    // ---------------- entry RAM: {page, frame, read_only} ----------------
    twar_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (scan_issue),
        .raddr(cnt_reg),
        .rdata(ram_rdata)
    );

    assign rd_page  = ram_rdata[WORD_W-1 -: PAGE_BITS];
    assign rd_frame = ram_rdata[1 +: FRAME_BITS];

    // write hit clears read-only; insert fills the victim
    always_comb begin
        ram_waddr = sel_idx_reg;
        if (func_reg == FUNC_INSERT) begin
            ram_we    = commit;
            ram_wdata = {page_reg, frame_reg, ro_reg};
        end else begin
            ram_we    = commit && found_reg && wr_reg;
            ram_wdata = {page_reg, hit_frame_reg, 1'b0};
        end
    end

    // ---------------- shared compare unit ----------------
    assign cmp_ctrl.lookup      = (func_reg == FUNC_LOOKUP);
    assign cmp_ctrl.first       = (cmp_idx_reg == '0);
    assign cmp_ctrl.entry_valid = valid_reg[cmp_idx_reg];
    assign cmp_ctrl.found       = found_reg;

    twar_cmp #(
        .PAGE_BITS(PAGE_BITS),
        .AGE_BITS (AGE_BITS)
    ) u_cmp (
        .ctrl      (cmp_ctrl),
        .entry_page(rd_page),
        .key_page  (page_reg),
        .entry_age (age_reg[cmp_idx_reg]),
        .best_age  (best_age_reg),
        .take      (cmp_take)
    );

    // ---------------- aging and fill ----------------
    // ages stay frozen during the scan, so the victim search sees pre-aging values
    always_comb begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            age_next[i] = age_reg[i];
        end
        if (commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                age_next[i] = age_reg[i] >> 1;
            end
            if (func_reg == FUNC_INSERT) begin
                age_next[sel_idx_reg]   = AGE_TOP;
                valid_next[sel_idx_reg] = 1'b1;
            end else if (found_reg) begin
                age_next[sel_idx_reg] = age_next[sel_idx_reg] | AGE_TOP;
            end
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= scan_issue;
            valid_reg   <= valid_next;
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= age_next[i];
            end
            if (s_fire) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end else if (scan_issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmp_vld_reg && cmp_take && (func_reg == FUNC_LOOKUP)) begin
                found_reg <= 1'b1;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg  <= s_func;
            page_reg  <= s_page;
            frame_reg <= s_frame;
            wr_reg    <= s_is_write;
            ro_reg    <= s_read_only;
        end
        cmp_idx_reg <= cnt_reg;
        if (cmp_vld_reg && cmp_take) begin
            sel_idx_reg   <= cmp_idx_reg;
            best_age_reg  <= age_reg[cmp_idx_reg];
            hit_frame_reg <= rd_frame;
        end
        if (commit) begin
            m_hit_reg   <= (func_reg == FUNC_LOOKUP) && found_reg;
            m_frame_reg <= ((func_reg == FUNC_LOOKUP) && found_reg) ? hit_frame_reg : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_found_frame = m_frame_reg;

    // ---------------- assertions ----------------
    // sel_idx_reg holds still in the idle cycle after an update
    assign ins_commit    = commit && (func_reg == FUNC_INSERT);
    assign victim_filled = valid_reg[sel_idx_reg] && (age_reg[sel_idx_reg] == AGE_TOP);

    `TWAR_ASSERT(a_busy_after_beat, aclk, aresetn, s_fire |=> !s_ready)
    `TWAR_ASSERT(a_found_only_lookup, aclk, aresetn, found_reg |-> (func_reg == FUNC_LOOKUP))
    `TWAR_ASSERT(a_insert_fills, aclk, aresetn, ins_commit |=> victim_filled)
    `TWAR_ASSERT_RST(a_reset_clears_out, aclk, !aresetn |=> !m_valid_reg)

endmodule
